/* rtl/core/swdap_pkg.sv */
// Shared constants and types for the SWD MEM-AP access decoder.
`timescale 1ns / 1ps

package swdap_pkg;

	// Width of the timestamp ports and result time fields
	localparam int unsigned PORT_TIME_W = 48;
	// Default width over which timestamps wrap
	localparam int unsigned TIME_BITS_DEF = 48;

	// Symbol kinds
	localparam logic [3:0] KIND_START      = 4'd0;
	localparam logic [3:0] KIND_AP_NDP     = 4'd1;
	localparam logic [3:0] KIND_R_NW       = 4'd2;
	localparam logic [3:0] KIND_ADDRESS    = 4'd3;
	localparam logic [3:0] KIND_PARITY_OK  = 4'd4;
	localparam logic [3:0] KIND_PARITY_BAD = 4'd5;
	localparam logic [3:0] KIND_STOP       = 4'd6;
	localparam logic [3:0] KIND_PARK       = 4'd7;
	localparam logic [3:0] KIND_TURNAROUND = 4'd8;
	localparam logic [3:0] KIND_ACK        = 4'd9;
	localparam logic [3:0] KIND_DATA       = 4'd10;
	localparam logic [3:0] KIND_OTHER      = 4'd11;

	// Ack code for OK
	localparam logic [31:0] ACK_OK = 32'd1;

	// Register byte addresses
	localparam logic [7:0] REG_DRW_RDBUFF = 8'h0C;
	localparam logic [7:0] REG_TAR        = 8'h04;

	// One memory access as it leaves the parser
	typedef struct packed {
		logic                   fire;
		logic                   is_write;
		logic [31:0]            mem_address;
		logic [31:0]            mem_data;
		logic [PORT_TIME_W-1:0] access_start;
		logic [PORT_TIME_W-1:0] access_length;
	} swdap_result_t;

endpackage

/* rtl/core/swdap_parser.sv */
// Packet sequencer: follows each SWD request and forms memory access results.
`timescale 1ns / 1ps

module swdap_parser #(
	parameter int unsigned TIME_W = swdap_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [3:0]                   symbol_kind,
	input  logic [31:0]                  symbol_value,
	input  logic [TIME_W-1:0]            symbol_start,
	input  logic [TIME_W-1:0]            symbol_end,
	output swdap_pkg::swdap_result_t     result
);
	import swdap_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TYPE, ST_RW, ST_ADDRESS, ST_HDR_PARITY, ST_STOP, ST_PARK,
		ST_HDR_TURN, ST_ACK, ST_DATA_TURN, ST_DATA, ST_DATA_PARITY
	} step_t;

	step_t             step_q, step_d;
	logic [TIME_W-1:0] pkt_start_q, pkt_start_d;
	logic [TIME_W-1:0] acc_start_q, acc_start_d;
	logic [7:0]        reg_addr_q, reg_addr_d;
	logic [31:0]       data_q, data_d;
	logic [31:0]       tar_q, tar_d;
	logic              is_read_q, is_read_d;
	logic              is_ap_q, is_ap_d;
	logic              first_rd_q, first_rd_d;
	logic              mem_hit;
	logic [TIME_W-1:0] length;

	assign length = symbol_end - acc_start_q;

	always_comb begin
		step_d      = ST_IDLE;
		pkt_start_d = pkt_start_q;
		acc_start_d = acc_start_q;
		reg_addr_d  = reg_addr_q;
		data_d      = data_q;
		tar_d       = tar_q;
		is_read_d   = is_read_q;
		is_ap_d     = is_ap_q;
		first_rd_d  = first_rd_q;
		mem_hit     = 1'b0;
		case (step_q)
			ST_IDLE: begin
				if (symbol_kind == KIND_START) begin
					pkt_start_d = symbol_start;
					step_d      = ST_TYPE;
				end
			end
			ST_TYPE: begin
				if (symbol_kind == KIND_AP_NDP) begin
					is_ap_d = (symbol_value == 32'd1);
					step_d  = ST_RW;
				end
			end
			ST_RW: begin
				if (symbol_kind == KIND_R_NW) begin
					is_read_d = (symbol_value != 32'd0);
					step_d    = ST_ADDRESS;
				end
			end
			ST_ADDRESS: begin
				if (symbol_kind == KIND_ADDRESS) begin
					reg_addr_d = symbol_value[7:0];
					step_d     = ST_HDR_PARITY;
				end
			end
			ST_HDR_PARITY: begin
				if (symbol_kind == KIND_PARITY_OK)
					step_d = ST_STOP;
			end
			ST_STOP: begin
				if (symbol_kind == KIND_STOP)
					step_d = ST_PARK;
			end
			ST_PARK: begin
				if (symbol_kind == KIND_PARK)
					step_d = ST_HDR_TURN;
			end
			ST_HDR_TURN: begin
				if (symbol_kind == KIND_TURNAROUND)
					step_d = ST_ACK;
			end
			ST_ACK: begin
				if (symbol_kind == KIND_ACK && symbol_value == ACK_OK)
					step_d = is_read_q ? ST_DATA : ST_DATA_TURN;
			end
			ST_DATA_TURN: begin
				if (symbol_kind == KIND_TURNAROUND)
					step_d = ST_DATA;
			end
			ST_DATA: begin
				if (symbol_kind == KIND_DATA) begin
					data_d = symbol_value;
					step_d = ST_DATA_PARITY;
				end
			end
			ST_DATA_PARITY: begin
				if (symbol_kind == KIND_PARITY_OK) begin
					if (is_ap_q) begin
						if (reg_addr_q == REG_DRW_RDBUFF) begin
							// drop the posted read that follows a TAR write
							if (first_rd_q && is_read_q)
								first_rd_d = 1'b0;
							else
								mem_hit = 1'b1;
						end
						if (!is_read_q && reg_addr_q == REG_TAR) begin
							tar_d       = data_q;
							first_rd_d  = 1'b1;
							acc_start_d = pkt_start_q;
						end
					end else if (reg_addr_q == REG_DRW_RDBUFF) begin
						mem_hit = 1'b1;
					end
					if (mem_hit)
						acc_start_d = symbol_end;
				end
			end
			default: begin
				step_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			pkt_start_q <= '0;
			acc_start_q <= '0;
			reg_addr_q  <= '0;
			data_q      <= '0;
			tar_q       <= '0;
			is_read_q   <= 1'b1;
			is_ap_q     <= 1'b0;
			first_rd_q  <= 1'b0;
		end else if (accept) begin
			step_q      <= step_d;
			pkt_start_q <= pkt_start_d;
			acc_start_q <= acc_start_d;
			reg_addr_q  <= reg_addr_d;
			data_q      <= data_d;
			tar_q       <= tar_d;
			is_read_q   <= is_read_d;
			is_ap_q     <= is_ap_d;
			first_rd_q  <= first_rd_d;
		end
	end

	always_comb begin
		result               = '0;
		result.fire          = accept & mem_hit;
		result.is_write      = ~is_read_q;
		result.mem_address   = tar_q;
		result.mem_data      = data_q;
		result.access_start  = PORT_TIME_W'(acc_start_q);
		result.access_length = PORT_TIME_W'(length);
	end

endmodule

/* rtl/core/swd_mem_ap_access_decoder_top.sv */
// Top level of the SWD MEM-AP access decoder: symbol channel, parser, result register.
`timescale 1ns / 1ps
//
// Usage
//   Symbol channel (symbol_valid / symbol_stall): one decoded SWD symbol per request,
//   with its kind, value and start and end timestamps. A request is taken at a rising
//   edge where symbol_valid is high and symbol_stall is low.
//   Result channel (result_valid / result_stall): one memory access per completed AP
//   DRW or DP RDBUFF transfer, the posted read after a TAR write excepted. Most
//   symbols cause no result.
//   A result appears in the cycle after its data parity symbol is taken.
//   Throughput: one symbol per cycle while symbol_stall is low. The sequencer updates
//   state once per taken symbol; only the result register lies between the channels.
//   Stall: while a result is held and the receiver stalls, symbol_stall is raised and
//   the sequencer holds; symbols that are taken while the result register drains or
//   is empty advance the sequencer without a bubble.
//   Timestamps wrap at TIME_BITS (capped at the 48-bit port width); access_length is
//   the wrapped difference, zero-extended to 48 bits.
//   Reset (arst_n low, asynchronous): sequencer returns to idle, TAR and timestamps
//   clear, the read flag sets, and the result register empties.
//
module swd_mem_ap_access_decoder_top #(
	parameter int unsigned TIME_BITS = swdap_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               symbol_valid,
	output logic                               symbol_stall,
	input  logic [3:0]                         symbol_kind,
	input  logic [31:0]                        symbol_value,
	input  logic [swdap_pkg::PORT_TIME_W-1:0]  symbol_start,
	input  logic [swdap_pkg::PORT_TIME_W-1:0]  symbol_end,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               is_write,
	output logic [31:0]                        mem_address,
	output logic [31:0]                        mem_data,
	output logic [swdap_pkg::PORT_TIME_W-1:0]  access_start,
	output logic [swdap_pkg::PORT_TIME_W-1:0]  access_length
);
	import swdap_pkg::*;

	// Timestamps wrap at the narrower of TIME_BITS and the port width
	localparam int unsigned TIME_W = (TIME_BITS < PORT_TIME_W) ? TIME_BITS : PORT_TIME_W;

	logic          sym_accept;
	swdap_result_t res;
	logic          res_valid_q;
	swdap_result_t res_q;

	// Hold the symbol side only while a result waits and the receiver stalls
	assign symbol_stall = res_valid_q & result_stall;
	assign sym_accept   = symbol_valid & ~symbol_stall;

	swdap_parser #(
		.TIME_W (TIME_W)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (sym_accept),
		.symbol_kind  (symbol_kind),
		.symbol_value (symbol_value),
		.symbol_start (symbol_start[TIME_W-1:0]),
		.symbol_end   (symbol_end[TIME_W-1:0]),
		.result       (res)
	);

	// Result register: load a new access, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res.fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			res_q <= res;
		end
	end

	assign result_valid  = res_valid_q;
	assign is_write      = res_q.is_write;
	assign mem_address   = res_q.mem_address;
	assign mem_data      = res_q.mem_data;
	assign access_start  = res_q.access_start;
	assign access_length = res_q.access_length;

	// A produced access always reaches the result register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |=> result_valid)
		else $error("produced access did not reach the result register");

	// The symbol side is only held back by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_stall |-> (result_valid && result_stall))
		else $error("symbol side stalled without a waiting result");

	// A held result is never overwritten by a new access
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !res.fire)
		else $error("new access produced while result held");

	// Time fields stay inside the wrap width
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((access_length >> TIME_W) == '0 && (access_start >> TIME_W) == '0))
		else $error("result time field beyond the wrap width");

endmodule
